// ----- rtl/itlrm_pkg.sv -----
// Shared types and constants for the I/O trace log with repeat merging.
// Holds the stream word layouts, ring entry layout and the controller links.
// No dependencies.
package itlrm_pkg;

   // Ring geometry (depth must be a power of two)
   localparam int LOG_DEPTH = 64;
   localparam int LOOKBACK  = 8;
   localparam int RING_AW   = $clog2(LOG_DEPTH);
   localparam int BACK_W    = $clog2(LOOKBACK + 2);

   // Fixed field widths
   localparam int SLOT_W     = 6;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 208;

   // Request kinds carried on req_tuser
   typedef enum logic [KIND_W-1:0] {
      KIND_LOG   = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   // Result status carried on rsp_tuser
   typedef enum logic [STATUS_W-1:0] {
      RSP_APPENDED   = 3'd0,
      RSP_MERGED     = 3'd1,
      RSP_READ_VALID = 3'd2,
      RSP_READ_EMPTY = 3'd3,
      RSP_CLEARED    = 3'd4
   } rsp_status_type;

   // Commit operation selected by the controller
   typedef enum logic [1:0] {
      OP_APPEND,
      OP_MERGE,
      OP_READ,
      OP_CLEAR
   } op_type;

   // Request word, lowest field last
   typedef struct packed {
      logic [5:0]        pad;
      logic [SLOT_W-1:0] slot_index;
      logic [15:0]       code_offset;
      logic [15:0]       code_segment;
      logic [31:0]       data_value;
      logic [15:0]       port_number;
      logic [2:0]        access_size;
      logic              access_dir;
   } req_data_type;

   // Result word, lowest field last
   typedef struct packed {
      logic [5:0]        pad;
      logic [15:0]       recent_port;
      logic [31:0]       entries_written;
      logic [31:0]       trap_total;
      logic [31:0]       entry_repeats;
      logic [31:0]       entry_location;
      logic [31:0]       entry_value;
      logic [15:0]       entry_port;
      logic [2:0]        entry_size;
      logic              entry_dir;
      logic [SLOT_W-1:0] slot_used;
   } rsp_data_type;

   // One ring entry
   typedef struct packed {
      logic        dir;
      logic [2:0]  size;
      logic [15:0] port;
      logic [31:0] value;
      logic [31:0] location;
      logic [31:0] repeats;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic   capture;
      logic   issue_look;
      logic   issue_read;
      logic   commit;
      op_type op;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              hit;
      logic              more;
      logic              out_free;
   } ctrl_stat_type;

endpackage

// ----- rtl/itlrm_ctrl.sv -----
// Sequencing controller for the I/O trace log.
// Walks the lookback entries and schedules the commit of each word.
// Depends on itlrm_pkg.
module itlrm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  itlrm_pkg::ctrl_stat_type stat,
   output itlrm_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_READ,
      S_FINISH
   } state_type;

   state_type          state_ff;
   logic               pend_ff;
   itlrm_pkg::op_type  op_ff;
   logic               accept;

   // Decode commands from the current state
   always_comb begin
      req_tready     = (state_ff == S_IDLE);
      accept         = req_tvalid && req_tready;
      cmd.capture    = 1'b0;
      cmd.issue_look = 1'b0;
      cmd.issue_read = 1'b0;
      cmd.commit     = 1'b0;
      cmd.op         = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = accept;
         end
         S_LOOK: begin
            cmd.issue_look = !(pend_ff && stat.hit) && stat.more;
         end
         S_READ: begin
            cmd.issue_read = 1'b1;
         end
         S_FINISH: begin
            cmd.commit = stat.out_free;
         end
         default: begin
         end
      endcase
   end

   // Advance the sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         op_ff    <= itlrm_pkg::OP_APPEND;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (stat.kind)
                     itlrm_pkg::KIND_LOG: begin
                        state_ff <= S_LOOK;
                        pend_ff  <= 1'b0;
                     end
                     itlrm_pkg::KIND_READ: begin
                        state_ff <= S_READ;
                     end
                     itlrm_pkg::KIND_CLEAR: begin
                        state_ff <= S_FINISH;
                        op_ff    <= itlrm_pkg::OP_CLEAR;
                     end
                     default: begin
                        // unknown kind: drop the word
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_LOOK: begin
               if (pend_ff && stat.hit) begin
                  state_ff <= S_FINISH;
                  op_ff    <= itlrm_pkg::OP_MERGE;
               end else if (stat.more) begin
                  pend_ff <= 1'b1;
               end else begin
                  state_ff <= S_FINISH;
                  op_ff    <= itlrm_pkg::OP_APPEND;
               end
            end
            S_READ: begin
               state_ff <= S_FINISH;
               op_ff    <= itlrm_pkg::OP_READ;
            end
            S_FINISH: begin
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- rtl/itlrm_dpath.sv -----
// Datapath of the I/O trace log: ring memory, counters, compare and result register.
// Driven by itlrm_ctrl through command and status structs.
// Depends on itlrm_pkg.
module itlrm_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [itlrm_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [itlrm_pkg::KIND_W-1:0]        req_tuser,
   input  itlrm_pkg::ctrl_cmd_type             cmd,
   output itlrm_pkg::ctrl_stat_type            stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [itlrm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [itlrm_pkg::STATUS_W-1:0]      rsp_tuser
);

   itlrm_pkg::req_data_type                 req_fields;
   itlrm_pkg::req_data_type                 cap_ff;
   logic [itlrm_pkg::KIND_W-1:0]            cap_kind_ff;
   logic [31:0]                             trap_ff, trap_in;
   logic [31:0]                             wtotal_ff, wtotal_in;
   logic [15:0]                             recent_ff, recent_in;
   logic [itlrm_pkg::BACK_W-1:0]            back_ff;
   itlrm_pkg::entry_type                    mem [itlrm_pkg::LOG_DEPTH];
   itlrm_pkg::entry_type                    rd_ff;
   logic [itlrm_pkg::RING_AW-1:0]           rd_slot_ff;
   logic [itlrm_pkg::LOG_DEPTH-1:0]         valid_ff;
   logic                                    out_valid_ff;
   itlrm_pkg::rsp_data_type                 out_data_ff, out_data_in;
   logic [itlrm_pkg::STATUS_W-1:0]          out_status_ff, out_status_in;

   logic [itlrm_pkg::RING_AW-1:0]           look_slot;
   logic [itlrm_pkg::RING_AW-1:0]           read_slot;
   logic [itlrm_pkg::RING_AW-1:0]           rd_addr;
   logic [itlrm_pkg::RING_AW-1:0]           wr_addr;
   itlrm_pkg::entry_type                    wr_entry;
   itlrm_pkg::entry_type                    show_entry;
   logic                                    read_ok;
   logic                                    do_write;

   assign req_fields = itlrm_pkg::req_data_type'(req_tdata);

   // Lookback and read addresses
   assign look_slot = itlrm_pkg::RING_AW'(wtotal_ff - 32'(back_ff));
   assign read_slot = itlrm_pkg::RING_AW'(cap_ff.slot_index);
   assign rd_addr   = cmd.issue_read ? read_slot : look_slot;
   assign read_ok   = (32'(cap_ff.slot_index) < 32'(itlrm_pkg::LOG_DEPTH)) &&
                      valid_ff[rd_slot_ff];

   // Status back to the controller
   assign stat.kind     = req_tuser;
   assign stat.hit      = (rd_ff.dir == cap_ff.access_dir) &&
                          (rd_ff.size == cap_ff.access_size) &&
                          (rd_ff.port == cap_ff.port_number) &&
                          (rd_ff.value == cap_ff.data_value) &&
                          (rd_ff.location == {cap_ff.code_segment, cap_ff.code_offset});
   assign stat.more     = (back_ff <= itlrm_pkg::BACK_W'(itlrm_pkg::LOOKBACK)) &&
                          (32'(back_ff) <= wtotal_ff);
   assign stat.out_free = !out_valid_ff || rsp_tready;

   // Entry to write: a fresh one, or the matched one with its count bumped
   always_comb begin
      if (cmd.op == itlrm_pkg::OP_APPEND) begin
         wr_addr           = itlrm_pkg::RING_AW'(wtotal_ff);
         wr_entry.dir      = cap_ff.access_dir;
         wr_entry.size     = cap_ff.access_size;
         wr_entry.port     = cap_ff.port_number;
         wr_entry.value    = cap_ff.data_value;
         wr_entry.location = {cap_ff.code_segment, cap_ff.code_offset};
         wr_entry.repeats  = 32'd1;
      end else begin
         wr_addr          = rd_slot_ff;
         wr_entry         = rd_ff;
         wr_entry.repeats = rd_ff.repeats + 32'd1;
      end
      do_write = cmd.commit &&
                 ((cmd.op == itlrm_pkg::OP_APPEND) || (cmd.op == itlrm_pkg::OP_MERGE));
   end

   // Ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_addr] <= wr_entry;
      end
      if (cmd.issue_look || cmd.issue_read) begin
         rd_ff      <= mem[rd_addr];
         rd_slot_ff <= rd_addr;
      end
   end

   // Next counter values
   always_comb begin
      trap_in   = trap_ff;
      wtotal_in = wtotal_ff;
      recent_in = recent_ff;
      if (cmd.capture && (req_tuser == itlrm_pkg::KIND_LOG)) begin
         trap_in   = trap_ff + 32'd1;
         recent_in = req_fields.port_number;
      end
      if (cmd.commit) begin
         case (cmd.op)
            itlrm_pkg::OP_APPEND: begin
               wtotal_in = wtotal_ff + 32'd1;
            end
            itlrm_pkg::OP_CLEAR: begin
               trap_in   = 32'd0;
               wtotal_in = 32'd0;
               recent_in = 16'd0;
            end
            default: begin
            end
         endcase
      end
   end

   // Build the result word
   always_comb begin
      show_entry    = '0;
      out_status_in = itlrm_pkg::RSP_CLEARED;
      out_data_in   = '0;
      case (cmd.op)
         itlrm_pkg::OP_APPEND: begin
            out_status_in         = itlrm_pkg::RSP_APPENDED;
            show_entry            = wr_entry;
            out_data_in.slot_used = itlrm_pkg::SLOT_W'(wr_addr);
         end
         itlrm_pkg::OP_MERGE: begin
            out_status_in         = itlrm_pkg::RSP_MERGED;
            show_entry            = wr_entry;
            out_data_in.slot_used = itlrm_pkg::SLOT_W'(wr_addr);
         end
         itlrm_pkg::OP_READ: begin
            out_data_in.slot_used = cap_ff.slot_index;
            if (read_ok) begin
               out_status_in = itlrm_pkg::RSP_READ_VALID;
               show_entry    = rd_ff;
            end else begin
               out_status_in = itlrm_pkg::RSP_READ_EMPTY;
            end
         end
         default: begin
         end
      endcase
      out_data_in.entry_dir       = show_entry.dir;
      out_data_in.entry_size      = show_entry.size;
      out_data_in.entry_port      = show_entry.port;
      out_data_in.entry_value     = show_entry.value;
      out_data_in.entry_location  = show_entry.location;
      out_data_in.entry_repeats   = show_entry.repeats;
      out_data_in.trap_total      = trap_in;
      out_data_in.entries_written = wtotal_in;
      out_data_in.recent_port     = recent_in;
   end

   // Hold the captured word and the result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_ff      <= req_fields;
         cap_kind_ff <= req_tuser;
      end
      if (cmd.commit) begin
         out_data_ff   <= out_data_in;
         out_status_ff <= out_status_in;
      end
   end

   // Counters, lookback step, valid bits and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         trap_ff      <= '0;
         wtotal_ff    <= '0;
         recent_ff    <= '0;
         back_ff      <= '0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         trap_ff   <= trap_in;
         wtotal_ff <= wtotal_in;
         recent_ff <= recent_in;
         if (cmd.capture) begin
            back_ff <= itlrm_pkg::BACK_W'(1);
         end else if (cmd.issue_look) begin
            back_ff <= back_ff + itlrm_pkg::BACK_W'(1);
         end
         if (do_write && (cmd.op == itlrm_pkg::OP_APPEND) &&
             (cap_kind_ff == itlrm_pkg::KIND_LOG)) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.commit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

// ----- rtl/io_trace_log_with_repeat_merge.sv -----
// I/O trace log with repeat merging: one result word per log, read or clear word.
// A log word compares up to LOOKBACK ring entries, newest first, before it merges or appends;
// read and clear words compare none. Words are handled one at a time: a new word is taken
// only after the last one has committed its result, and the single ring read port walks
// one lookback entry a cycle. A new word is taken while a result waits.
// Synchronous reset clears the counters, slot valid bits and handshake state.
module io_trace_log_with_repeat_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // access_dir[0], access_size[3:1], port_number[19:4], data_value[51:20],
   // code_segment[67:52], code_offset[83:68], slot_index[89:84], zero pad above
   input  logic [itlrm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind[1:0]
   input  logic [itlrm_pkg::KIND_W-1:0]      req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // slot_used[5:0], entry_dir[6], entry_size[9:7], entry_port[25:10],
   // entry_value[57:26], entry_location[89:58], entry_repeats[121:90],
   // trap_total[153:122], entries_written[185:154], recent_port[201:186], zero pad above
   output logic [itlrm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status[2:0]
   output logic [itlrm_pkg::STATUS_W-1:0]    rsp_tuser
);

   itlrm_pkg::ctrl_cmd_type  cmd;
   itlrm_pkg::ctrl_stat_type stat;

   itlrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   itlrm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- tb/sv/trace_log_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the I/O trace log: watches both stream channels, predicts
// each result word from accepted request words and compares them in order.
// Depends on itlrm_pkg for the word layouts, kinds and status codes.
module trace_log_checker
   import itlrm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [KIND_W-1:0]      req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [STATUS_W-1:0]    rsp_tuser,
   output int                     mismatches,
   output int                     pending_words,
   output int                     results_checked,
   output logic [LOG_DEPTH-1:0]   slots_filled
);

   typedef struct packed {
      rsp_status_type status;
      rsp_data_type   word;
   } due_result_type;

   // Shadow of the trace ring and its counters
   entry_type            trace_ring [LOG_DEPTH];
   logic [LOG_DEPTH-1:0] ring_filled;
   logic [31:0]          append_total;
   logic [31:0]          log_total;
   logic [15:0]          latest_port;
   due_result_type       due_results [$];

   initial begin
      mismatches      = 0;
      results_checked = 0;
      pending_words   = 0;
      slots_filled    = '0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on result word %0d: %s is 0x%08h, expected 0x%08h",
               results_checked, what, got, want);
      mismatches++;
   endtask

   // Entry fields of one ring slot as they appear in a result word
   function automatic rsp_data_type show_entry(input logic [RING_AW-1:0] pos);
      rsp_data_type w;
      w                = '0;
      w.slot_used      = pos;
      w.entry_dir      = trace_ring[pos].dir;
      w.entry_size     = trace_ring[pos].size;
      w.entry_port     = trace_ring[pos].port;
      w.entry_value    = trace_ring[pos].value;
      w.entry_location = trace_ring[pos].location;
      w.entry_repeats  = trace_ring[pos].repeats;
      return w;
   endfunction

   // Update the shadow state for one request word and queue its result
   task automatic predict_result(input logic [KIND_W-1:0] kind, input req_data_type req);
      due_result_type  res;
      entry_type       access;
      logic [31:0]     walk;
      logic [RING_AW-1:0] pos;
      logic            hit;
      res = '0;
      pos = '0;
      hit = 1'b0;
      case (kind)
         KIND_LOG: begin
            log_total   = log_total + 32'd1;
            latest_port = req.port_number;
            access.dir      = req.access_dir;
            access.size     = req.access_size;
            access.port     = req.port_number;
            access.value    = req.data_value;
            access.location = {req.code_segment, req.code_offset};
            access.repeats  = 32'd1;
            // walk back over the newest entries, newest first
            for (int back = 1; back <= LOOKBACK; back++) begin
               if (!hit && 32'(back) <= append_total) begin
                  walk = append_total - 32'(back);
                  if (ring_filled[walk[RING_AW-1:0]] &&
                      trace_ring[walk[RING_AW-1:0]].dir == access.dir &&
                      trace_ring[walk[RING_AW-1:0]].size == access.size &&
                      trace_ring[walk[RING_AW-1:0]].port == access.port &&
                      trace_ring[walk[RING_AW-1:0]].value == access.value &&
                      trace_ring[walk[RING_AW-1:0]].location == access.location) begin
                     hit = 1'b1;
                     pos = walk[RING_AW-1:0];
                  end
               end
            end
            if (hit) begin
               trace_ring[pos].repeats = trace_ring[pos].repeats + 32'd1;
               res.status = RSP_MERGED;
            end else begin
               pos              = append_total[RING_AW-1:0];
               trace_ring[pos]  = access;
               ring_filled[pos] = 1'b1;
               append_total     = append_total + 32'd1;
               res.status       = RSP_APPENDED;
            end
            res.word = show_entry(pos);
         end
         KIND_READ: begin
            pos = req.slot_index;
            if (ring_filled[pos]) begin
               res.status = RSP_READ_VALID;
               res.word   = show_entry(pos);
            end else begin
               res.status         = RSP_READ_EMPTY;
               res.word.slot_used = req.slot_index;
            end
         end
         KIND_CLEAR: begin
            log_total    = '0;
            append_total = '0;
            latest_port  = '0;
            res.status   = RSP_CLEARED;
         end
         default: return;
      endcase
      res.word.trap_total      = log_total;
      res.word.entries_written = append_total;
      res.word.recent_port     = latest_port;
      due_results.push_back(res);
   endtask

   always @(posedge clock) begin : watch
      rsp_data_type   got;
      due_result_type due;
      if (reset) begin
         ring_filled  = '0;
         append_total = '0;
         log_total    = '0;
         latest_port  = '0;
         due_results.delete();
      end else begin
         // compare the result word against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_data_type'(rsp_tdata);
            if (due_results.size() == 0) begin
               report_mismatch("status of word with nothing expected", 32'(rsp_tuser), '0);
            end else begin
               due = due_results.pop_front();
               if (rsp_tuser !== due.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(due.status));
               if (got.slot_used !== due.word.slot_used)
                  report_mismatch("slot_used", 32'(got.slot_used), 32'(due.word.slot_used));
               if (got.entry_dir !== due.word.entry_dir)
                  report_mismatch("entry_dir", 32'(got.entry_dir), 32'(due.word.entry_dir));
               if (got.entry_size !== due.word.entry_size)
                  report_mismatch("entry_size", 32'(got.entry_size), 32'(due.word.entry_size));
               if (got.entry_port !== due.word.entry_port)
                  report_mismatch("entry_port", 32'(got.entry_port), 32'(due.word.entry_port));
               if (got.entry_value !== due.word.entry_value)
                  report_mismatch("entry_value", got.entry_value, due.word.entry_value);
               if (got.entry_location !== due.word.entry_location)
                  report_mismatch("entry_location", got.entry_location,
                                  due.word.entry_location);
               if (got.entry_repeats !== due.word.entry_repeats)
                  report_mismatch("entry_repeats", got.entry_repeats, due.word.entry_repeats);
               if (got.trap_total !== due.word.trap_total)
                  report_mismatch("trap_total", got.trap_total, due.word.trap_total);
               if (got.entries_written !== due.word.entries_written)
                  report_mismatch("entries_written", got.entries_written,
                                  due.word.entries_written);
               if (got.recent_port !== due.word.recent_port)
                  report_mismatch("recent_port", 32'(got.recent_port),
                                  32'(due.word.recent_port));
            end
            results_checked++;
         end
         // predict after comparing, so a word never meets its own result
         if (req_tvalid && req_tready)
            predict_result(req_tuser, req_data_type'(req_tdata));
      end
      pending_words <= due_results.size();
      slots_filled  <= ring_filled;
   end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Top of the I/O trace log testbench: clock, reset, request stimulus, result
// back-pressure, watchdog and verdict. Depends on itlrm_pkg, the block and
// trace_log_checker.
module tb;
   import itlrm_pkg::*;

   localparam int ITEM_TARGET     = 1450;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int MAX_GAP         = 12;
   localparam int HOLD_OFF_AFTER  = 500;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int POOL_DEPTH      = 12;
   localparam int NO_CLEAR_BEFORE = 300;
   // the one kind code the block ignores
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [KIND_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;

   int                     mismatches;
   int                     pending_words;
   int                     results_checked;
   logic [LOG_DEPTH-1:0]   slots_filled;

   int                     logs_sent, reads_sent, clears_sent, unused_sent;
   int                     send_burst;
   req_data_type           recent_logs [$];

   io_trace_log_with_repeat_merge dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   trace_log_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatches      (mismatches),
      .pending_words   (pending_words),
      .results_checked (results_checked),
      .slots_filled    (slots_filled)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Offer one request word after a random gap and hold it until taken
   task automatic send_word(input logic [KIND_W-1:0] kind, input req_data_type word);
      int gap;
      if (send_burst > 0) begin
         gap = 0;
         send_burst--;
      end else begin
         gap = $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 39) == 0) send_burst = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      case (kind)
         KIND_LOG:   logs_sent++;
         KIND_READ:  reads_sent++;
         KIND_CLEAR: clears_sent++;
         default:    unused_sent++;
      endcase
   endtask

   function automatic req_data_type random_word();
      req_data_type w;
      w = {$urandom, $urandom, $urandom};
      w.pad = '0;
      return w;
   endfunction

   function automatic req_data_type make_log(input logic dir, input logic [2:0] size,
                                             input logic [15:0] port, input logic [31:0] value,
                                             input logic [15:0] seg, input logic [15:0] off);
      req_data_type w;
      w              = random_word();
      w.access_dir   = dir;
      w.access_size  = size;
      w.port_number  = port;
      w.data_value   = value;
      w.code_segment = seg;
      w.code_offset  = off;
      return w;
   endfunction

   // Log an access and remember it for later repeats
   task automatic send_log(input req_data_type word);
      recent_logs.push_back(word);
      if (recent_logs.size() > POOL_DEPTH) void'(recent_logs.pop_front());
      send_word(KIND_LOG, word);
   endtask

   task automatic send_read(input logic [SLOT_W-1:0] slot);
      req_data_type w;
      w            = random_word();
      w.slot_index = slot;
      send_word(KIND_READ, w);
   endtask

   // Read a slot that has been written at least once
   task automatic send_filled_read();
      logic [SLOT_W-1:0] slot;
      slot = SLOT_W'($urandom_range(0, LOG_DEPTH - 1));
      while (!slots_filled[slot]) slot = slot + 1'b1;
      send_read(slot);
   endtask

   // Result side: random stalls, one long hold-off to back the block up
   initial begin : result_side
      int hold, taken, burst;
      taken = 0;
      burst = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_OFF_AFTER) begin
            hold = HOLD_OFF_CYCLES;
         end else if (burst > 0) begin
            hold = 0;
            burst--;
         end else begin
            hold = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 39) == 0) burst = $urandom_range(10, 40);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

   // End the run when neither channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      req_data_type first, far, w;
      req_data_type spread [7];
      int counted, sel, mode;
      logs_sent   = 0;
      reads_sent  = 0;
      clears_sent = 0;
      unused_sent = 0;
      send_burst  = 0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // all-zero access, then its repeat merges into slot 0
      first = make_log(1'b0, 3'd1, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000);
      send_log(first);
      send_log(first);
      // all-ones access, then one differing from the first only in direction
      far = make_log(1'b1, 3'd4, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_log(far);
      send_log(make_log(1'b1, 3'd1, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000));
      // fill up to nine entries so lookback edges can be hit
      for (int i = 0; i < 5; i++) begin
         spread[i] = make_log(1'($urandom_range(0, 1)), 3'($urandom_range(1, 4)),
                              16'($urandom), 32'($urandom), 16'($urandom),
                              16'($urandom));
         send_log(spread[i]);
      end
      spread[6] = make_log(1'b0, 3'd3, 16'h5A5A, 32'hA5A5_5A5A, 16'h1234, 16'hFEDC);
      send_log(spread[6]);
      // slot 1 is eight back: merges; slot 0 is nine back: appends
      send_log(far);
      send_log(first);
      send_read(6'd1);
      send_word(KIND_UNUSED, random_word());
      send_word(KIND_CLEAR, random_word());
      // ring contents survive a clear
      send_read(6'd9);
      // after a clear nothing is looked back at: an old twin appends, then merges
      send_log(first);
      send_log(first);
      send_read(6'd0);
      send_filled_read();

      // random part: mostly accesses, most of them repeats or near misses of recent ones
      counted = 0;
      while (counted < ITEM_TARGET) begin
         sel = $urandom_range(0, 199);
         if (sel < 10) begin
            send_word(KIND_UNUSED, random_word());
         end else begin
            if (sel < 11 && counted > NO_CLEAR_BEFORE) begin
               send_word(KIND_CLEAR, random_word());
            end else if (sel < 55) begin
               send_filled_read();
            end else begin
               mode = $urandom_range(0, 9);
               if (mode < 6 && recent_logs.size() > 0) begin
                  w = recent_logs[$urandom_range(0, recent_logs.size() - 1)];
                  // near miss: change a single field
                  if (mode >= 4) begin
                     case ($urandom_range(0, 5))
                        0: w.access_dir   = ~w.access_dir;
                        1: w.access_size  = 3'($urandom_range(1, 4));
                        2: w.port_number  = w.port_number ^ (16'd1 << $urandom_range(0, 15));
                        3: w.data_value   = w.data_value ^ (32'd1 << $urandom_range(0, 31));
                        4: w.code_segment = w.code_segment ^ (16'd1 << $urandom_range(0, 15));
                        default: w.code_offset = w.code_offset ^ (16'd1 << $urandom_range(0, 15));
                     endcase
                  end
                  w.slot_index = SLOT_W'($urandom);
               end else begin
                  w = random_word();
                  w.access_size = 3'($urandom_range(1, 4));
               end
               send_log(w);
            end
         end
         counted++;
      end
      req_tvalid <= 1'b0;

      // drain outstanding results, then allow any stray word to show up
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d logged accesses, %0d slot reads, %0d clears and %0d ignored words;",
               logs_sent, reads_sent, clears_sent, unused_sent);
      $display("%0d result words checked, with a %0d-cycle result hold-off along the way.",
               results_checked, HOLD_OFF_CYCLES);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- io_trace_log_with_repeat_merge.f -----
rtl/itlrm_pkg.sv
rtl/itlrm_ctrl.sv
rtl/itlrm_dpath.sv
rtl/io_trace_log_with_repeat_merge.sv
tb/sv/trace_log_checker.sv
tb/sv/tb.sv
